FILE: hdl/wts_pkg.sv
// Shared types, constants and helpers for the wave-table sound channel.
package wts_pkg;

    // Field widths
    localparam int OP_W      = 3;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 8;
    localparam int CYCLES_W  = 10;
    localparam int SAMPLE_W  = 5;

    // Control register file
    localparam int NUM_REGS  = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_VOLUME  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LENGTH  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DAC     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FREQ_LO = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FREQ_HI = 3'd4;
    localparam logic [DATA_W-1:0] REG_RESET [NUM_REGS] =
        '{8'h7F, 8'hFF, 8'h9F, 8'hBF, 8'h00};

    // Wave RAM
    localparam int WAVE_BYTES = 16;
    localparam int WAVE_AW    = $clog2(WAVE_BYTES);
    localparam int POS_W      = WAVE_AW + 1;

    // Channel timers
    localparam int LENGTH_W   = 9;
    localparam logic [LENGTH_W-1:0] LENGTH_FULL = 9'd256;
    localparam int COUNT_W    = 15;
    localparam logic [11:0] PERIOD_BASE = 12'd2048;
    localparam int TRIG_BIT   = 7;

    typedef enum logic [OP_W-1:0] {
        OP_REG_WRITE  = 3'd0,
        OP_WAVE_WRITE = 3'd1,
        OP_LENGTH     = 3'd2,
        OP_ADVANCE    = 3'd3,
        OP_REG_READ   = 3'd4,
        OP_WAVE_READ  = 3'd5
    } op_t;

    // Countdown reload: (2048 - period) * 4
    function automatic logic [COUNT_W-1:0] reload_value(
        input logic [DATA_W-1:0] freq_lo,
        input logic [DATA_W-1:0] freq_hi
    );
        logic [11:0] diff;
        diff = PERIOD_BASE - {1'b0, freq_hi[2:0], freq_lo};
        return {1'b0, diff, 2'b00};
    endfunction

endpackage

FILE: hdl/wts_if.sv
// Request and result channel interfaces of the wave-table sound channel.
interface wts_req_if;
    logic                           valid;
    logic                           ready;
    logic [wts_pkg::OP_W-1:0]       operation;
    logic [wts_pkg::ADDR_W-1:0]     address;
    logic [wts_pkg::DATA_W-1:0]     write_data;
    logic [wts_pkg::CYCLES_W-1:0]   cycle_count;

    modport source (output valid, operation, address, write_data, cycle_count,
                    input ready);
    modport sink   (input valid, operation, address, write_data, cycle_count,
                    output ready);
endinterface

interface wts_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [wts_pkg::DATA_W-1:0]         read_data;
    logic signed [wts_pkg::SAMPLE_W-1:0] sample_numerator;
    logic                               channel_on;

    modport source (output valid, read_data, sample_numerator, channel_on,
                    input ready);
    modport sink   (input valid, read_data, sample_numerator, channel_on,
                    output ready);
endinterface

FILE: hdl/wave_table_sound_channel.sv
// Wave-table sound channel: control registers, wave RAM, timers and sample output.
//
// Usage
//   req carries one request per accept: a register write, wave RAM write,
//   length tick, advance by cycle_count, register read or wave RAM read.
//   rsp returns exactly one result per request, in order: read_data (0 unless
//   a read), sample_numerator (output level over 15) and channel_on, all
//   reflecting the channel state after that request.
// Timing
//   A request is captured in an input register, processed by one pass of logic
//   once the result stage is free and lands in the result register, which
//   drives rsp.valid. One request per cycle is sustained while rsp.ready is high;
//   the limit is one state update a clock.
// Reset
//   Control registers return to 7F FF 9F BF 00, wave RAM clears, the channel
//   is disabled and both stages are emptied.
// Back-pressure
//   While rsp.ready is low the result holds; the input register still takes
//   one more request, after which req.ready drops until the result drains.
module wave_table_sound_channel (
    input  logic        clk,
    input  logic        rst_n,
    wts_req_if.sink     req,
    wts_rsp_if.source   rsp
);

    // Input stage
    logic                               req_valid_reg;
    logic [wts_pkg::OP_W-1:0]           req_op_reg;
    logic [wts_pkg::ADDR_W-1:0]         req_addr_reg;
    logic [wts_pkg::DATA_W-1:0]         req_data_reg;
    logic [wts_pkg::CYCLES_W-1:0]       req_cycles_reg;

    // Result stage
    logic                               rsp_valid_reg;
    logic [wts_pkg::DATA_W-1:0]         rsp_data_reg;
    logic [wts_pkg::DATA_W-1:0]         rsp_data_next;
    logic [wts_pkg::SAMPLE_W-1:0]       rsp_sample_reg;
    logic [wts_pkg::SAMPLE_W-1:0]       rsp_sample_next;
    logic                               rsp_on_reg;

    // Channel state
    logic [wts_pkg::DATA_W-1:0]   ctrl_reg  [wts_pkg::NUM_REGS];
    logic [wts_pkg::DATA_W-1:0]   ctrl_next [wts_pkg::NUM_REGS];
    logic [wts_pkg::DATA_W-1:0]   wave_reg  [wts_pkg::WAVE_BYTES];
    logic [wts_pkg::DATA_W-1:0]   wave_next [wts_pkg::WAVE_BYTES];
    logic                         enabled_reg, enabled_next;
    logic                         dac_reg, dac_next;
    logic [wts_pkg::LENGTH_W-1:0] length_reg, length_next;
    logic [1:0]                   volume_reg, volume_next;
    logic [wts_pkg::POS_W-1:0]    position_reg, position_next;
    logic [wts_pkg::COUNT_W-1:0]  countdown_reg, countdown_next;
    logic [3:0]                   latch_reg, latch_next;

    logic                         process;
    logic [wts_pkg::POS_W-1:0]    position_inc;
    logic [wts_pkg::WAVE_AW-1:0]  wave_rd_idx;
    logic [wts_pkg::DATA_W-1:0]   wave_rd_byte;
    logic                         reg_addr_ok;
    logic [wts_pkg::REG_IDX_W-1:0] reg_idx;

    // Handshake: the input stage moves on when the result stage is free
    assign process   = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || process;

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.read_data        = rsp_data_reg;
    assign rsp.sample_numerator = rsp_sample_reg;
    assign rsp.channel_on       = rsp_on_reg;

    // Single wave RAM read port, shared by wave reads and sample steps
    assign position_inc = position_reg + 1'b1;
    assign wave_rd_idx  = (req_op_reg == wts_pkg::OP_WAVE_READ)
                        ? req_addr_reg[wts_pkg::WAVE_AW-1:0]
                        : position_inc[wts_pkg::POS_W-1:1];
    assign wave_rd_byte = wave_reg[wave_rd_idx];

    assign reg_addr_ok = (req_addr_reg < wts_pkg::ADDR_W'(wts_pkg::NUM_REGS));
    assign reg_idx     = req_addr_reg[wts_pkg::REG_IDX_W-1:0];

    // Operation decode and next state
    always_comb
    begin
        logic [3:0] level;
        logic [wts_pkg::SAMPLE_W-1:0] scaled;

        ctrl_next      = ctrl_reg;
        wave_next      = wave_reg;
        enabled_next   = enabled_reg;
        dac_next       = dac_reg;
        length_next    = length_reg;
        volume_next    = volume_reg;
        position_next  = position_reg;
        countdown_next = countdown_reg;
        latch_next     = latch_reg;
        rsp_data_next  = '0;

        case (req_op_reg)
            wts_pkg::OP_REG_WRITE:
            begin
                if (reg_addr_ok)
                begin
                    ctrl_next[reg_idx] = req_data_reg;
                    // Trigger: bit 7 written to register 4 with the DAC on
                    if (reg_idx == wts_pkg::REG_FREQ_HI && req_data_reg[wts_pkg::TRIG_BIT]
                        && ctrl_reg[wts_pkg::REG_DAC][wts_pkg::TRIG_BIT])
                    begin
                        dac_next       = 1'b1;
                        enabled_next   = 1'b1;
                        length_next    = {1'b0, ctrl_reg[wts_pkg::REG_LENGTH]};
                        volume_next    = ctrl_reg[wts_pkg::REG_VOLUME][6:5];
                        position_next  = wts_pkg::POS_W'(1);
                        countdown_next = wts_pkg::reload_value(
                            ctrl_reg[wts_pkg::REG_FREQ_LO], req_data_reg);
                    end
                end
            end
            wts_pkg::OP_WAVE_WRITE:
            begin
                wave_next[req_addr_reg[wts_pkg::WAVE_AW-1:0]] = req_data_reg;
            end
            wts_pkg::OP_LENGTH:
            begin
                if (length_reg < wts_pkg::LENGTH_FULL)
                begin
                    length_next = length_reg + 1'b1;
                    if (length_next == wts_pkg::LENGTH_FULL)
                    begin
                        enabled_next = 1'b0;
                        ctrl_next[wts_pkg::REG_FREQ_HI][wts_pkg::TRIG_BIT] = 1'b0;
                    end
                end
            end
            wts_pkg::OP_ADVANCE:
            begin
                if (enabled_reg)
                begin
                    if ({5'd0, req_cycles_reg} >= countdown_reg)
                    begin
                        countdown_next = wts_pkg::reload_value(
                            ctrl_reg[wts_pkg::REG_FREQ_LO], ctrl_reg[wts_pkg::REG_FREQ_HI]);
                        position_next  = position_inc;
                        // Upper nibble on even positions
                        latch_next     = position_inc[0] ? wave_rd_byte[3:0]
                                                         : wave_rd_byte[7:4];
                    end
                    else
                    begin
                        countdown_next = countdown_reg - {5'd0, req_cycles_reg};
                    end
                end
            end
            wts_pkg::OP_REG_READ:
            begin
                rsp_data_next = reg_addr_ok ? ctrl_reg[reg_idx] : '0;
            end
            wts_pkg::OP_WAVE_READ:
            begin
                rsp_data_next = wave_rd_byte;
            end
            default:
            begin
                rsp_data_next = '0;
            end
        endcase

        // Output level from the updated state
        case (volume_next)
            2'd2:    level = {1'b0, latch_next[3:1]};
            2'd3:    level = {2'b00, latch_next[3:2]};
            default: level = latch_next;
        endcase
        scaled = {level, 1'b0} - wts_pkg::SAMPLE_W'(15);

        if (!dac_next)
            rsp_sample_next = '0;
        else if (!enabled_next)
            rsp_sample_next = wts_pkg::SAMPLE_W'(15);
        else if (volume_next == 2'd0)
            rsp_sample_next = '0;
        else
            rsp_sample_next = scaled;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            req_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_op_reg     <= req.operation;
            req_addr_reg   <= req.address;
            req_data_reg   <= req.write_data;
            req_cycles_reg <= req.cycle_count;
        end
    end

    // Channel state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= wts_pkg::REG_RESET;
            for (int i = 0; i < wts_pkg::WAVE_BYTES; i++)
            begin
                wave_reg[i] <= '0;
            end
            enabled_reg   <= 1'b0;
            dac_reg       <= 1'b0;
            length_reg    <= wts_pkg::LENGTH_FULL;
            volume_reg    <= '0;
            position_reg  <= wts_pkg::POS_W'(1);
            countdown_reg <= '0;
            latch_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (process)
            begin
                ctrl_reg      <= ctrl_next;
                wave_reg      <= wave_next;
                enabled_reg   <= enabled_next;
                dac_reg       <= dac_next;
                length_reg    <= length_next;
                volume_reg    <= volume_next;
                position_reg  <= position_next;
                countdown_reg <= countdown_next;
                latch_reg     <= latch_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            rsp_data_reg   <= rsp_data_next;
            rsp_sample_reg <= rsp_sample_next;
            rsp_on_reg     <= enabled_next;
        end
    end

endmodule
